@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros for the RTL of the core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define YPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define YPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ypa_pkg.sv @@
// ---------------------------------------------------------------------------
// ypa_pkg
// Types, constants and tables of the Yukawa potential accumulator.
// ---------------------------------------------------------------------------
package ypa_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int DECAY_WIDTH   = 24;
  localparam int SUM_WIDTH     = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int KAPPA_FRAC    = 16;
  localparam int EXP_FRAC      = 30;
  localparam int EXP_TERMS     = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int MAG_WIDTH     = COORD_WIDTH;
  localparam int ROOT_WIDTH    = COORD_WIDTH + 1;
  localparam int MUL_WIDTH     = 34;
  localparam int RECIP_SHIFT   = 34;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] target_z;
    logic signed [COORD_WIDTH-1:0] source_x;
    logic signed [COORD_WIDTH-1:0] source_y;
    logic signed [COORD_WIDTH-1:0] source_z;
    logic signed [COORD_WIDTH-1:0] source_weight;
    logic                          skip_source;
    logic                          first_source;
    logic                          last_source;
  } item_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] potential;
    logic                        saturated;
  } result_t;

  typedef struct packed {
    logic [MAG_WIDTH-1:0]          dmag_x;
    logic [MAG_WIDTH-1:0]          dmag_y;
    logic [MAG_WIDTH-1:0]          dmag_z;
    logic signed [COORD_WIDTH-1:0] weight;
    logic                          skip;
    logic                          first;
    logic                          last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_SQ,
    B_SQ_ACC,
    B_SQRT,
    B_RCHK,
    B_KMUL,
    B_KCHK,
    B_SER_MUL,
    B_SER_DIV,
    B_SER_ADD,
    B_SER_END,
    B_POW_MUL,
    B_POW_RND,
    B_FMUL,
    B_FRND,
    B_DIV,
    B_KRND,
    B_WMUL,
    B_WADD,
    B_EMIT
  } back_state_t;

  // ceil(2^34 / n): x / n == (x * recip) >> 34 for x <= 2^30, n in 2..16
  function automatic logic [MUL_WIDTH-1:0] recip_lut(input logic [4:0] n);
    logic [MUL_WIDTH-1:0] r;
    unique case (n)
      5'd2:    r = 34'd8589934592;
      5'd3:    r = 34'd5726623062;
      5'd4:    r = 34'd4294967296;
      5'd5:    r = 34'd3435973837;
      5'd6:    r = 34'd2863311531;
      5'd7:    r = 34'd2454267027;
      5'd8:    r = 34'd2147483648;
      5'd9:    r = 34'd1908874354;
      5'd10:   r = 34'd1717986919;
      5'd11:   r = 34'd1561806290;
      5'd12:   r = 34'd1431655766;
      5'd13:   r = 34'd1321528399;
      5'd14:   r = 34'd1227133514;
      5'd15:   r = 34'd1145324613;
      5'd16:   r = 34'd1073741824;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/yukawa_potential_accumulate_core.sv @@
// ---------------------------------------------------------------------------
// yukawa_potential_accumulate_core
// Sums the screened Coulomb potential at one target over a run of sources.
// ---------------------------------------------------------------------------
// Input: drive in_item and raise push; the transaction takes place at an
// edge with push high and full low. A two-entry command queue sits behind
// the front, so push is taken while the back is busy until it fills.
// Results: while empty is low, out_result holds the potential and the
// saturation flag of a finished run; pop takes it. A held result does not
// stop the back: it finishes the next item and waits only if that item
// ends a run too.
// The back's time per item is set by the one shared 34x34 multiplier,
// the bit-serial square root (33 steps), the two 16-term exponential
// series and the bit-serial divider (31 + FRAC_BITS steps); a skipped
// item, a source that sits on the target and kappa * R reaching 32 take
// shorter paths. Empty drops once the back has finished an item that ends
// a run and the result slot is free; a held result delays it until popped.
// cfg_we writes the screening constant; write only while the block is idle.
// Reset (synchronous, rst_n low) clears target, sum, flag, queue and result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module yukawa_potential_accumulate_core import ypa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  item_t                  in_item,
  input  logic                   push,
  output logic                   full,
  output result_t                out_result,
  output logic                   empty,
  input  logic                   pop,
  input  logic                   cfg_we,
  input  logic [DECAY_WIDTH-1:0] cfg_wdata
);

  logic [DECAY_WIDTH-1:0] decay_r;
  logic                   in_accept;
  cmd_t                   front_cmd, q_cmd;
  qstat_t                 q_stat;
  logic                   q_pop;
  logic                   res_valid;
  logic                   res_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= '0;
    end else if (cfg_we) begin
      decay_r <= cfg_wdata;
    end
  end

  assign in_accept = push && !q_stat.full;
  assign full      = q_stat.full;
  assign empty     = !res_valid;

  ypa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .accept  (in_accept),
    .cmd     (front_cmd)
  );

  ypa_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_accept),
    .wr_cmd (front_cmd),
    .rd_en  (q_pop),
    .rd_cmd (q_cmd),
    .stat   (q_stat)
  );

  ypa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .decay_rate (decay_r),
    .q_stat     (q_stat),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .res_pop    (pop && res_valid),
    .res        (out_result),
    .res_valid  (res_valid),
    .res_emit   (res_emit)
  );

  `YPA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "result pending after reset")
  `YPA_ASSERT(a_queue_flags, !(q_stat.empty && q_stat.full), "queue both empty and full")
  `YPA_ASSERT(a_result_source, $fell(empty) |-> $past(res_emit), "result without emit")

endmodule

@@ sv/ypa_front.sv @@
// ---------------------------------------------------------------------------
// ypa_front
// Latches the target and turns each item into a distance command.
// ---------------------------------------------------------------------------
module ypa_front import ypa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  item_t in_item,
  input  logic  accept,
  output cmd_t  cmd
);

  logic signed [COORD_WIDTH-1:0] tgt_x_r, tgt_y_r, tgt_z_r;
  logic signed [COORD_WIDTH-1:0] tx, ty, tz;
  logic signed [COORD_WIDTH:0]   dx, dy, dz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_x_r <= '0;
      tgt_y_r <= '0;
      tgt_z_r <= '0;
    end else if (accept && in_item.first_source) begin
      tgt_x_r <= in_item.target_x;
      tgt_y_r <= in_item.target_y;
      tgt_z_r <= in_item.target_z;
    end
  end

  // a first item measures against its own target
  assign tx = in_item.first_source ? in_item.target_x : tgt_x_r;
  assign ty = in_item.first_source ? in_item.target_y : tgt_y_r;
  assign tz = in_item.first_source ? in_item.target_z : tgt_z_r;

  assign dx = {tx[COORD_WIDTH-1], tx} - {in_item.source_x[COORD_WIDTH-1], in_item.source_x};
  assign dy = {ty[COORD_WIDTH-1], ty} - {in_item.source_y[COORD_WIDTH-1], in_item.source_y};
  assign dz = {tz[COORD_WIDTH-1], tz} - {in_item.source_z[COORD_WIDTH-1], in_item.source_z};

  always_comb begin
    cmd.dmag_x = dx[COORD_WIDTH] ? MAG_WIDTH'(-dx) : MAG_WIDTH'(dx);
    cmd.dmag_y = dy[COORD_WIDTH] ? MAG_WIDTH'(-dy) : MAG_WIDTH'(dy);
    cmd.dmag_z = dz[COORD_WIDTH] ? MAG_WIDTH'(-dz) : MAG_WIDTH'(dz);
    cmd.weight = in_item.source_weight;
    cmd.skip   = in_item.skip_source;
    cmd.first  = in_item.first_source;
    cmd.last   = in_item.last_source;
  end

endmodule

@@ sv/ypa_queue.sv @@
// ---------------------------------------------------------------------------
// ypa_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module ypa_queue import ypa_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  cmd_t   wr_cmd,
  input  logic   rd_en,
  output cmd_t   rd_cmd,
  output qstat_t stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign rd_cmd     = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));

endmodule

@@ sv/ypa_back.sv @@
// ---------------------------------------------------------------------------
// ypa_back
// Sequencer that evaluates one kernel term on a shared multiplier and sums.
// ---------------------------------------------------------------------------
module ypa_back import ypa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [DECAY_WIDTH-1:0] decay_rate,
  input  qstat_t                 q_stat,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  input  logic                   res_pop,
  output result_t                res,
  output logic                   res_valid,
  output logic                   res_emit
);

  localparam int PROD_W   = 2 * MUL_WIDTH;
  localparam int RAD_W    = 2 * ROOT_WIDTH;
  localparam int SQ_W     = 2 * MAG_WIDTH;
  localparam int KPROD_W  = DECAY_WIDTH + ROOT_WIDTH;
  localparam int A_W      = EXP_FRAC + 5;
  localparam int E_W      = EXP_FRAC + 1;
  localparam int SER_W    = EXP_FRAC + 4;
  localparam int DIV_W    = E_W + FRAC_BITS;
  localparam int KER_W    = COORD_WIDTH - 1;
  localparam int CNT_W    = $clog2(DIV_W + 1);
  localparam int A_SUM    = FRAC_BITS + KAPPA_FRAC;
  localparam int A_SHR    = (A_SUM >= EXP_FRAC) ? A_SUM - EXP_FRAC : 0;
  localparam int A_SHL    = (A_SUM >= EXP_FRAC) ? 0 : EXP_FRAC - A_SUM;
  localparam int WP_W     = 2 * COORD_WIDTH - 1;

  localparam logic [KPROD_W-1:0] EXP_LIM  = KPROD_W'(1) << (21 + FRAC_BITS);
  localparam logic [E_W-1:0]     EXP_ONE  = E_W'(1) << EXP_FRAC;
  localparam logic [KER_W-1:0]   KMAX     = '1;
  localparam logic [PROD_W-1:0]  QHALF    = PROD_W'(1) << (EXP_FRAC - 1);
  localparam logic [DIV_W:0]     KHALF    = (DIV_W + 1)'(1) << (EXP_FRAC - 1 - FRAC_BITS);
  localparam logic [SUM_WIDTH-1:0] WHALF  = SUM_WIDTH'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r;

  logic signed [SUM_WIDTH-1:0] sum_r;
  logic                        sat_r;
  result_t                     res_r;
  logic                        res_valid_r;

  logic [PROD_W-1:0]     prod_r;
  logic [MUL_WIDTH-1:0]  mul_a, mul_b;
  logic [RAD_W-1:0]      rad_r;
  logic [ROOT_WIDTH:0]   rem_r;
  logic [ROOT_WIDTH-1:0] root_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [4:0]            nexp_r;
  logic [EXP_FRAC-1:0]   frac_r;
  logic [E_W-1:0]        f_r, term_r, e1_r, s_r, e_r;
  logic signed [SER_W-1:0] ser_r;
  logic [4:0]            n_r;
  logic                  sel_r;
  logic [DIV_W-1:0]      num_r;
  logic [ROOT_WIDTH-1:0] drem_r;
  logic [KER_W-1:0]      kern_r;

  logic                   slot_free;
  logic [COORD_WIDTH-1:0] wmag;
  logic [MAG_WIDTH-1:0]   sq_op;
  logic [E_W-1:0]         ser_x, ser_t, qround, clamped;
  logic [ROOT_WIDTH+2:0]  rem_sh;
  logic [ROOT_WIDTH+2:0]  trial;
  logic [ROOT_WIDTH:0]    drem_sh;
  logic [KPROD_W-1:0]     kp;
  logic [KPROD_W+7:0]     a_wide;
  logic [PROD_W-1:0]      qsum;
  logic [DIV_W:0]         kq;
  logic [SUM_WIDTH-1:0]   wp, tl;
  logic signed [SUM_WIDTH-1:0] term;
  logic signed [SUM_WIDTH:0]   sum_x;

  assign slot_free = !res_valid_r || res_pop;
  assign wmag      = cmd_r.weight[COORD_WIDTH-1] ? COORD_WIDTH'(-cmd_r.weight)
                                                  : COORD_WIDTH'(cmd_r.weight);

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    sq_op = cmd_r.dmag_x;
      2'd1:    sq_op = cmd_r.dmag_y;
      default: sq_op = cmd_r.dmag_z;
    endcase
  end

  // datapath taps
  assign ser_x   = prod_r[EXP_FRAC +: E_W];
  assign ser_t   = prod_r[RECIP_SHIFT +: E_W];
  assign qsum    = prod_r + QHALF;
  assign qround  = qsum[EXP_FRAC +: E_W];
  assign rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign drem_sh = {drem_r, num_r[DIV_W-1]};
  assign kp      = prod_r[KPROD_W-1:0];
  assign a_wide  = ({8'b0, kp} >> A_SHR) << A_SHL;
  assign kq      = ({1'b0, num_r} + KHALF) >> (EXP_FRAC - FRAC_BITS);
  assign wp      = {1'b0, prod_r[WP_W-1:0]} + WHALF;
  assign tl      = wp >> FRAC_BITS;
  assign term    = cmd_r.weight[COORD_WIDTH-1] ? -$signed(tl) : $signed(tl);
  assign sum_x   = {sum_r[SUM_WIDTH-1], sum_r} + {term[SUM_WIDTH-1], term};

  always_comb begin
    if (ser_r < 0) begin
      clamped = '0;
    end else if (ser_r > $signed({{(SER_W-E_W){1'b0}}, EXP_ONE})) begin
      clamped = EXP_ONE;
    end else begin
      clamped = ser_r[E_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = q_cmd.skip ? B_EMIT : B_SQ;
        end
      end
      B_SQ:      state_nxt = B_SQ_ACC;
      B_SQ_ACC:  state_nxt = (cnt_r == CNT_W'(2)) ? B_SQRT : B_SQ;
      B_SQRT:    state_nxt = (cnt_r == CNT_W'(ROOT_WIDTH - 1)) ? B_RCHK : B_SQRT;
      B_RCHK:    state_nxt = (root_r == '0) ? B_WMUL : B_KMUL;
      B_KMUL:    state_nxt = B_KCHK;
      B_KCHK:    state_nxt = (kp >= EXP_LIM) ? B_WMUL : B_SER_MUL;
      B_SER_MUL: state_nxt = B_SER_DIV;
      B_SER_DIV: state_nxt = (n_r == 5'd1) ? B_SER_MUL : B_SER_ADD;
      B_SER_ADD: state_nxt = (n_r == 5'(EXP_TERMS)) ? B_SER_END : B_SER_MUL;
      B_SER_END: begin
        if (!sel_r) begin
          state_nxt = B_SER_MUL;
        end else begin
          state_nxt = (nexp_r == '0) ? B_FMUL : B_POW_MUL;
        end
      end
      B_POW_MUL: state_nxt = B_POW_RND;
      B_POW_RND: state_nxt = (cnt_r == CNT_W'(1)) ? B_FMUL : B_POW_MUL;
      B_FMUL:    state_nxt = B_FRND;
      B_FRND:    state_nxt = B_DIV;
      B_DIV:     state_nxt = (cnt_r == CNT_W'(DIV_W - 1)) ? B_KRND : B_DIV;
      B_KRND:    state_nxt = B_WMUL;
      B_WMUL:    state_nxt = B_WADD;
      B_WADD:    state_nxt = B_EMIT;
      B_EMIT: begin
        if (!cmd_r.last || slot_free) begin
          state_nxt = B_IDLE;
        end
      end
      default:   state_nxt = B_IDLE;
    endcase
  end

  // outputs: multiplier operands and handshakes
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    q_pop    = 1'b0;
    res_emit = 1'b0;
    unique case (state_r)
      B_IDLE:    q_pop = !q_stat.empty;
      B_SQ: begin
        mul_a = MUL_WIDTH'(sq_op);
        mul_b = MUL_WIDTH'(sq_op);
      end
      B_KMUL: begin
        mul_a = MUL_WIDTH'(decay_rate);
        mul_b = MUL_WIDTH'(root_r);
      end
      B_SER_MUL: begin
        mul_a = MUL_WIDTH'(term_r);
        mul_b = MUL_WIDTH'(f_r);
      end
      B_SER_DIV: begin
        mul_a = MUL_WIDTH'(ser_x);
        mul_b = recip_lut(n_r);
      end
      B_POW_MUL: begin
        mul_a = MUL_WIDTH'(e_r);
        mul_b = MUL_WIDTH'(e1_r);
      end
      B_FMUL: begin
        mul_a = MUL_WIDTH'(e_r);
        mul_b = MUL_WIDTH'(s_r);
      end
      B_WMUL: begin
        mul_a = MUL_WIDTH'(wmag);
        mul_b = MUL_WIDTH'(kern_r);
      end
      B_EMIT:    res_emit = cmd_r.last && slot_free;
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sum_r       <= '0;
      sat_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_emit) begin
        res_valid_r <= 1'b1;
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
      if (q_pop && q_cmd.first) begin
        sum_r <= '0;
        sat_r <= 1'b0;
      end
      if (state_r == B_RCHK && root_r == '0) begin
        sat_r <= 1'b1;
      end
      if (state_r == B_KRND && kq > (DIV_W + 1)'(KMAX)) begin
        sat_r <= 1'b1;
      end
      if (state_r == B_WADD) begin
        if (sum_x[SUM_WIDTH] != sum_x[SUM_WIDTH-1]) begin
          sum_r <= term[SUM_WIDTH-1] ? SUM_MIN : SUM_MAX;
          sat_r <= 1'b1;
        end else begin
          sum_r <= sum_x[SUM_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_emit) begin
      res_r.potential <= sum_r;
      res_r.saturated <= sat_r;
    end
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          cmd_r <= q_cmd;
        end
        rad_r <= '0;
        cnt_r <= '0;
      end
      B_SQ_ACC: begin
        rad_r <= rad_r + RAD_W'(prod_r[SQ_W-1:0]);
        if (cnt_r == CNT_W'(2)) begin
          cnt_r  <= '0;
          rem_r  <= '0;
          root_r <= '0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      B_SQRT: begin
        if (rem_sh >= trial) begin
          rem_r  <= (ROOT_WIDTH + 1)'(rem_sh - trial);
          root_r <= {root_r[ROOT_WIDTH-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[ROOT_WIDTH:0];
          root_r <= {root_r[ROOT_WIDTH-2:0], 1'b0};
        end
        rad_r <= rad_r << 2;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      B_RCHK: begin
        if (root_r == '0) begin
          kern_r <= KMAX;
        end
      end
      B_KCHK: begin
        // exponent of 32 or more: exponential is taken as zero
        kern_r <= '0;
        nexp_r <= a_wide[EXP_FRAC +: 5];
        frac_r <= a_wide[EXP_FRAC-1:0];
        sel_r  <= 1'b0;
        f_r    <= EXP_ONE;
        term_r <= EXP_ONE;
        ser_r  <= SER_W'(EXP_ONE);
        n_r    <= 5'd1;
      end
      B_SER_DIV: begin
        if (n_r == 5'd1) begin
          term_r <= ser_x;
          ser_r  <= ser_r - $signed(SER_W'(ser_x));
          n_r    <= n_r + 5'd1;
        end
      end
      B_SER_ADD: begin
        term_r <= ser_t;
        if (n_r[0]) begin
          ser_r <= ser_r - $signed(SER_W'(ser_t));
        end else begin
          ser_r <= ser_r + $signed(SER_W'(ser_t));
        end
        n_r <= n_r + 5'd1;
      end
      B_SER_END: begin
        if (!sel_r) begin
          e1_r   <= clamped;
          sel_r  <= 1'b1;
          f_r    <= {1'b0, frac_r};
          term_r <= EXP_ONE;
          ser_r  <= SER_W'(EXP_ONE);
          n_r    <= 5'd1;
        end else begin
          s_r   <= clamped;
          e_r   <= EXP_ONE;
          cnt_r <= CNT_W'(nexp_r);
        end
      end
      B_POW_RND: begin
        e_r   <= qround;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      B_FRND: begin
        num_r  <= {qround, {FRAC_BITS{1'b0}}};
        drem_r <= '0;
        cnt_r  <= '0;
      end
      B_DIV: begin
        if (drem_sh >= {1'b0, root_r}) begin
          drem_r <= ROOT_WIDTH'(drem_sh - {1'b0, root_r});
          num_r  <= {num_r[DIV_W-2:0], 1'b1};
        end else begin
          drem_r <= drem_sh[ROOT_WIDTH-1:0];
          num_r  <= {num_r[DIV_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
      B_KRND: begin
        kern_r <= (kq > (DIV_W + 1)'(KMAX)) ? KMAX : kq[KER_W-1:0];
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule
